FILE: rtl/sbsu_pkg.sv
// ----------------------------------------------------------------------------
// sbsu_pkg: shared types and constants
// Mode, fault and command codes, state and register records for the
// supercapacitor backup supervisor.
// ----------------------------------------------------------------------------
package sbsu_pkg;

	localparam logic [31:0] SAMPLE_MS         = 32'd20;
	localparam logic [31:0] STAT_LOW_MS       = 32'd100;
	localparam logic [31:0] DECAY_MS          = 32'd100;
	localparam logic [31:0] CHARGE_TIMEOUT_MS = 32'd7200000;
	localparam logic [11:0] TS_MIN_MV         = 12'd1300;
	localparam logic [11:0] TS_MAX_MV         = 12'd2350;

	// Bit positions in the enable word.
	localparam int EN_CHG   = 0;
	localparam int EN_BOOST = 1;
	localparam int EN_BUCK  = 2;

	typedef enum logic [2:0] {
		M_STOPPED  = 3'd0,
		M_CHARGING = 3'd1,
		M_READY    = 3'd2,
		M_BACKUP   = 3'd3,
		M_RETURNED = 3'd4,
		M_FAULT    = 3'd5,
		M_CUTOFF   = 3'd6
	} mode_t;

	typedef enum logic [4:0] {
		F_NONE      = 5'd0,
		F_BUDGET    = 5'd1,
		F_BUS       = 5'd2,
		F_DRIVER    = 5'd3,
		F_SOURCE    = 5'd4,
		F_VSTART    = 5'd5,
		F_THERM     = 5'd6,
		F_STOP      = 5'd7,
		F_LOSS_SHUT = 5'd8,
		F_UNARMED   = 5'd9,
		F_VINVALID  = 5'd10,
		F_OVERVOLT  = 5'd11,
		F_PG5V      = 5'd12,
		F_BACKUP_PG = 5'd13,
		F_CHG_STATE = 5'd14,
		F_STAT      = 5'd15,
		F_TIMEOUT   = 5'd16
	} fault_t;

	typedef enum logic [1:0] {
		CUT_NONE    = 2'd0,
		CUT_TIMEOUT = 2'd1,
		CUT_LOWV    = 2'd2
	} reason_t;

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_START = 2'd1,
		FN_STOP  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		CFG_GRACE    = 3'd0,
		CFG_ARM      = 3'd1,
		CFG_CUTOFF   = 3'd2,
		CFG_TRIP     = 3'd3,
		CFG_FULL_MIN = 3'd4,
		CFG_FULL_MAX = 3'd5,
		CFG_SPAN     = 3'd6,
		CFG_PLATEAU  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [19:0] grace_ms;
		logic [14:0] arm_mv;
		logic [14:0] cutoff_mv;
		logic [14:0] trip_mv;
		logic [14:0] full_min_mv;
		logic [14:0] full_max_mv;
		logic [10:0] span_mv;
		logic [19:0] plateau_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		grace_ms: 20'd20000, arm_mv: 15'd10000, cutoff_mv: 15'd7000,
		trip_mv: 15'd21000, full_min_mv: 15'd20000, full_max_mv: 15'd20950,
		span_mv: 11'd150, plateau_ms: 20'd30000
	};

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] now_ms;
		logic        budget_ok;
		logic        status_ok;
		logic [7:0]  pg_flags;
		logic        outputs_ok;
		logic        vcap_valid;
		logic [14:0] vcap_mv;
		logic [11:0] ts_mv;
		logic        actions_ok;
		logic        backup_pin;
	} item_t;

	typedef struct packed {
		mode_t       mode;
		logic        monitoring;
		logic        stop_req;
		logic        loss_active;
		logic [31:0] loss_start;
		logic        bk_seen;
		logic [31:0] bk_seen_at;
		logic        bk_done;
		logic [31:0] bk_done_at;
		logic        plat_on;
		logic [31:0] plat_start;
		logic [14:0] plat_low;
		logic [14:0] plat_high;
		logic        stat_low_on;
		logic [31:0] stat_low_start;
		logic [31:0] charge_start;
		logic [31:0] last_sample;
		logic [15:0] loss_cnt;
		logic        armed;
		logic        pending;
		logic        ce_off_done;
		logic [31:0] ce_off_time;
		logic        cleanup_good;
		reason_t     reason;
		fault_t      fault;
		logic [2:0]  en;
	} st_t;

	localparam st_t ST_RESET = '{
		mode: M_STOPPED, reason: CUT_NONE, fault: F_NONE, cleanup_good: 1'b1,
		default: '0
	};

	typedef struct packed {
		logic [19:0] loss_remaining_ms;
		logic [31:0] backup_ms;
		logic [15:0] loss_count;
		logic        shutdown_pending;
		logic        backup_armed;
		logic        buck_on;
		logic        boost_on;
		logic        charger_on;
		logic        ok;
		logic [4:0]  fault_code;
		logic [1:0]  cutoff_reason;
		logic [2:0]  mode;
	} res_t;

endpackage

FILE: rtl/supercap_backup_supervisor_unit.sv
// ----------------------------------------------------------------------------
// supercap_backup_supervisor_unit: supercapacitor backup bank supervisor
// Tracks mode, faults, source-loss episodes and the split shutdown.
// ----------------------------------------------------------------------------
// Usage:
//   Commands and status samples enter on the s_ channel (kind in s_tuser);
//   each transfer yields exactly one status record on the m_ channel.
//   An accepted item waits in the input register, the update logic runs, and
//   the record lands in the output register that drives m_tvalid. One item per
//   cycle is sustained while the receiver accepts, set by the single state
//   register that every item reads and writes. When the receiver stalls, the
//   output register holds its record and the input register holds one more
//   item; s_tready drops only when both are full. Reset (arst_n low) returns
//   all state and the eight registers to their defaults and empties both
//   registers. The user must write registers through cfg_we/cfg_index/cfg_data
//   only while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module supercap_backup_supervisor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// now_ms, budget_ok, status_ok, pg_flags, outputs_ok, vcap_valid, vcap_mv,
	// ts_mv, actions_ok, backup_pin; zero filled to 80 bits
	input  logic [79:0] s_tdata,
	// func
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mode, cutoff_reason, fault_code, ok, charger_on, boost_on, buck_on,
	// backup_armed, shutdown_pending, loss_count, backup_ms, loss_remaining_ms;
	// zero filled to 88 bits
	output logic [87:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import sbsu_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	st_t   st_q;
	st_t   st_n;
	cfg_t  cfg_q;
	res_t  res;
	res_t  out_q;
	logic  out_valid_q;
	logic  adv;
	item_t item_in;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_comb begin
		item_in.func       = s_tuser;
		item_in.now_ms     = s_tdata[31:0];
		item_in.budget_ok  = s_tdata[32];
		item_in.status_ok  = s_tdata[33];
		item_in.pg_flags   = s_tdata[41:34];
		item_in.outputs_ok = s_tdata[42];
		item_in.vcap_valid = s_tdata[43];
		item_in.vcap_mv    = s_tdata[58:44];
		item_in.ts_mv      = s_tdata[70:59];
		item_in.actions_ok = s_tdata[71];
		item_in.backup_pin = s_tdata[72];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_s1 <= item_in;
	end

	sbsu_step u_step (
		.st   (st_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.st_n (st_n),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) st_q <= st_n;
			if (adv) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GRACE:    cfg_q.grace_ms <= cfg_data;
				CFG_ARM:      cfg_q.arm_mv <= cfg_data[14:0];
				CFG_CUTOFF:   cfg_q.cutoff_mv <= cfg_data[14:0];
				CFG_TRIP:     cfg_q.trip_mv <= cfg_data[14:0];
				CFG_FULL_MIN: cfg_q.full_min_mv <= cfg_data[14:0];
				CFG_FULL_MAX: cfg_q.full_max_mv <= cfg_data[14:0];
				CFG_SPAN:     cfg_q.span_mv <= cfg_data[10:0];
				CFG_PLATEAU:  cfg_q.plateau_ms <= cfg_data;
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q};

endmodule

FILE: rtl/sbsu_step.sv
// ----------------------------------------------------------------------------
// sbsu_step: next-state and result logic
// Applies one start, stop, status sample or spare command to the supervisor state.
// ----------------------------------------------------------------------------
module sbsu_step (
	input  sbsu_pkg::st_t   st,
	input  sbsu_pkg::cfg_t  cfg,
	input  sbsu_pkg::item_t item,
	output sbsu_pkg::st_t   st_n,
	output sbsu_pkg::res_t  res
);
	import sbsu_pkg::*;

	function automatic logic f_due(st_t s, logic [31:0] now, logic [19:0] grace);
		return s.loss_active && ((now - s.loss_start) >= {12'd0, grace});
	endfunction

	function automatic st_t f_begin(st_t s, logic [31:0] now, logic act);
		st_t r;
		r = s;
		r.pending = 1'b1;
		r.en[EN_CHG] = 1'b0;
		r.ce_off_done = act;
		if (act) r.ce_off_time = now;
		r.cleanup_good = act;
		return r;
	endfunction

	function automatic st_t f_finish(st_t s, logic [31:0] now, logic act);
		st_t r;
		r = s;
		if (r.pending) begin
			if (!r.ce_off_done) begin
				r.en[EN_CHG] = 1'b0;
				r.ce_off_done = act;
				if (act) r.ce_off_time = now;
				r.cleanup_good = 1'b0;
			end else if ((now - r.ce_off_time) >= DECAY_MS) begin
				r.en[EN_BOOST] = 1'b0;
				r.en[EN_BUCK] = 1'b0;
				r.cleanup_good = act;
				if (act) r.pending = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic st_t f_latch(st_t s, fault_t code, logic [31:0] now, logic act);
		st_t r;
		r = s;
		if (r.fault == F_NONE) r.fault = code;
		r.mode = M_FAULT;
		r.plat_on = 1'b0;
		r.monitoring = 1'b1;
		if (!r.pending) r = f_begin(r, now, act);
		return r;
	endfunction

	function automatic st_t f_cut(st_t s, reason_t why, logic [31:0] now);
		st_t r;
		r = s;
		if (r.bk_seen && !r.bk_done) begin
			r.bk_done_at = now;
			r.bk_done = 1'b1;
		end
		r.reason = why;
		r.mode = M_CUTOFF;
		r.monitoring = 1'b0;
		return r;
	endfunction

	// One status sample. Early exits of the sequence are tracked with done.
	function automatic st_t f_service(st_t s, cfg_t c, item_t it, output logic ok);
		st_t   r;
		logic  done;
		logic  mv;
		logic  act;
		logic [31:0] now;
		r = s;
		done = 1'b0;
		ok = 1'b0;
		now = it.now_ms;
		act = it.actions_ok;
		mv = it.pg_flags[0] && (it.pg_flags[1] || it.pg_flags[2]);
		if (!r.monitoring) begin
			ok = (r.mode != M_FAULT);
		end else if ((now - r.last_sample) < SAMPLE_MS && !f_due(r, now, c.grace_ms)) begin
			ok = (r.mode != M_FAULT);
		end else begin
			r.last_sample = now;
			if (!it.status_ok) begin
				if (f_due(r, now, c.grace_ms)) begin
					r = f_cut(r, CUT_TIMEOUT, now);
					ok = 1'b1;
				end else begin
					r = f_latch(r, F_BUS, now, act);
					r = f_finish(r, now, act);
					if (f_due(r, now, c.grace_ms)) begin
						r = f_cut(r, CUT_TIMEOUT, now);
						ok = 1'b1;
					end
				end
			end else begin
				if (!mv && !r.loss_active) begin
					r.loss_active = 1'b1;
					if (r.loss_cnt != 16'hFFFF) r.loss_cnt = r.loss_cnt + 16'd1;
					r.loss_start = now;
					r.bk_seen = 1'b0;
					r.bk_done = 1'b0;
					r.bk_seen_at = '0;
					r.bk_done_at = '0;
					r.plat_on = 1'b0;
					if (r.mode != M_FAULT && !r.stop_req) r.mode = M_BACKUP;
					r = f_begin(r, now, act);
					if (!act) r = f_latch(r, F_LOSS_SHUT, now, act);
					if (!r.armed) r = f_latch(r, F_UNARMED, now, act);
				end
				if (r.loss_active && !it.pg_flags[0] && it.pg_flags[4] && it.pg_flags[3]
						&& r.armed && !r.bk_seen) begin
					r.bk_seen = 1'b1;
					r.bk_seen_at = now;
				end
				if (r.loss_active && mv) begin
					r.loss_active = 1'b0;
					if (r.bk_seen && !r.bk_done) begin
						r.bk_done_at = now;
						r.bk_done = 1'b1;
					end
					if (r.mode != M_FAULT && !r.stop_req) r.mode = M_RETURNED;
				end
				if (f_due(r, now, c.grace_ms)) begin
					r = f_cut(r, CUT_TIMEOUT, now);
					ok = 1'b1;
					done = 1'b1;
				end
				if (!done) begin
					r = f_finish(r, now, act);
					done = 1'b1;
					if (!it.vcap_valid) begin
						r = f_latch(r, F_VINVALID, now, act);
					end else if (it.vcap_mv >= c.trip_mv && r.mode != M_FAULT) begin
						r = f_latch(r, F_OVERVOLT, now, act);
					end else if (!mv && r.armed && it.vcap_mv <= c.cutoff_mv) begin
						r = f_cut(r, CUT_LOWV, now);
						ok = 1'b1;
					end else if (!it.pg_flags[3] && r.mode != M_FAULT) begin
						r = f_latch(r, F_PG5V, now, act);
					end else if (r.armed && !it.pg_flags[4] && r.mode != M_FAULT) begin
						r = f_latch(r, F_BACKUP_PG, now, act);
					end else begin
						done = 1'b0;
					end
				end
				if (!done && (r.mode == M_CHARGING || r.mode == M_READY)) begin
					if (!it.pg_flags[5] || !it.pg_flags[6] || !it.outputs_ok) begin
						r = f_latch(r, F_CHG_STATE, now, act);
						done = 1'b1;
					end else if (it.ts_mv < TS_MIN_MV || it.ts_mv > TS_MAX_MV) begin
						r = f_latch(r, F_THERM, now, act);
						done = 1'b1;
					end else begin
						if (!it.pg_flags[7]) begin
							if (!r.stat_low_on) begin
								r.stat_low_on = 1'b1;
								r.stat_low_start = now;
							end
							if ((now - r.stat_low_start) >= STAT_LOW_MS) begin
								r = f_latch(r, F_STAT, now, act);
								done = 1'b1;
							end
						end else begin
							r.stat_low_on = 1'b0;
						end
						if (!done && !r.armed && it.vcap_mv >= c.arm_mv) begin
							r.armed = it.backup_pin;
							if (!act) begin
								r = f_latch(r, F_DRIVER, now, act);
								done = 1'b1;
							end
						end
						if (!done) begin
							if (r.mode == M_READY && it.vcap_mv < c.full_min_mv) begin
								r.mode = M_CHARGING;
								r.plat_on = 1'b0;
							end
							if (r.mode == M_CHARGING) begin
								if (it.vcap_mv >= c.full_min_mv && it.vcap_mv <= c.full_max_mv
										&& it.pg_flags[7]) begin
									if (!r.plat_on) begin
										r.plat_on = 1'b1;
										r.plat_start = now;
										r.plat_low = it.vcap_mv;
										r.plat_high = it.vcap_mv;
									end
									if (it.vcap_mv < r.plat_low) r.plat_low = it.vcap_mv;
									if (it.vcap_mv > r.plat_high) r.plat_high = it.vcap_mv;
									if ((r.plat_high - r.plat_low) > {4'd0, c.span_mv}) begin
										r.plat_start = now;
										r.plat_low = it.vcap_mv;
										r.plat_high = it.vcap_mv;
									end
									if ((now - r.plat_start) >= {12'd0, c.plateau_ms}
											&& r.armed && it.pg_flags[4])
										r.mode = M_READY;
								end else begin
									r.plat_on = 1'b0;
								end
								if (r.mode == M_CHARGING
										&& (now - r.charge_start) >= CHARGE_TIMEOUT_MS) begin
									r = f_latch(r, F_TIMEOUT, now, act);
									done = 1'b1;
								end
							end
						end
					end
				end
				if (!done) begin
					if (r.stop_req && !r.armed && !r.pending && mv) r.monitoring = 1'b0;
					ok = (r.mode != M_FAULT);
				end
			end
		end
		return r;
	endfunction

	st_t         s;
	logic        ok;
	logic        mv;
	logic        okv;
	logic        svc_ok;
	logic [31:0] now;
	logic [31:0] el;
	logic [31:0] bms;
	logic [19:0] rem;

	assign now = item.now_ms;
	assign mv  = item.pg_flags[0] && (item.pg_flags[1] || item.pg_flags[2]);

	always_comb begin
		s = st;
		ok = 1'b0;
		okv = 1'b0;
		svc_ok = 1'b0;
		case (item.func)
			FN_TICK: begin
				s = f_service(st, cfg, item, svc_ok);
				ok = svc_ok;
			end
			FN_START: begin
				if (s.mode == M_CUTOFF) begin
					ok = 1'b0;
				end else if (s.mode == M_CHARGING || s.mode == M_READY) begin
					ok = 1'b1;
				end else if (!s.pending) begin
					s.fault = F_NONE;
					s.stop_req = 1'b0;
					s.cleanup_good = 1'b1;
					if (!item.budget_ok) begin
						s = f_latch(s, F_BUDGET, now, item.actions_ok);
					end else if (!item.status_ok) begin
						s = f_latch(s, F_BUS, now, item.actions_ok);
					end else if (!mv || item.pg_flags[1] == item.pg_flags[2]
							|| !item.pg_flags[3]) begin
						s = f_latch(s, F_SOURCE, now, item.actions_ok);
					end else if (!item.vcap_valid || item.vcap_mv >= cfg.trip_mv) begin
						s = f_latch(s, F_VSTART, now, item.actions_ok);
					end else begin
						s.en = '0;
						if (!item.actions_ok) begin
							s = f_latch(s, F_DRIVER, now, item.actions_ok);
						end else begin
							s.en[EN_BOOST] = 1'b1;
							if (item.ts_mv < TS_MIN_MV || item.ts_mv > TS_MAX_MV) begin
								s = f_latch(s, F_THERM, now, item.actions_ok);
							end else begin
								s.en[EN_CHG] = 1'b1;
								s.mode = M_CHARGING;
								s.monitoring = 1'b1;
								s.charge_start = now;
								s.last_sample = now - SAMPLE_MS;
								s.loss_start = '0;
								s.bk_seen_at = '0;
								s.bk_done_at = '0;
								s.loss_cnt = '0;
								s.loss_active = 1'b0;
								s.bk_seen = 1'b0;
								s.bk_done = 1'b0;
								s.reason = CUT_NONE;
								s.plat_on = 1'b0;
								s.stat_low_on = 1'b0;
								s = f_service(s, cfg, item, svc_ok);
								ok = svc_ok;
							end
						end
					end
				end
			end
			FN_STOP: begin
				if (s.mode != M_CUTOFF) begin
					s.stop_req = 1'b1;
					s.mode = M_STOPPED;
					s.plat_on = 1'b0;
					s.monitoring = 1'b1;
					s = f_begin(s, now, item.actions_ok);
					okv = item.actions_ok;
					if (item.status_ok) begin
						if (mv && s.armed) begin
							if (item.actions_ok) s.armed = 1'b0;
							okv = item.actions_ok && okv;
						end
					end else begin
						okv = 1'b0;
					end
					if (!okv) s = f_latch(s, F_STOP, now, item.actions_ok);
					ok = okv;
				end
			end
			default: ok = (s.mode != M_FAULT);
		endcase
	end

	always_comb begin
		bms = '0;
		if (s.bk_seen) bms = (s.bk_done ? s.bk_done_at : now) - s.bk_seen_at;
		el = now - s.loss_start;
		rem = '0;
		if (s.loss_active && el < {12'd0, cfg.grace_ms})
			rem = cfg.grace_ms - el[19:0];
	end

	assign st_n = s;

	always_comb begin
		res.mode              = s.mode;
		res.cutoff_reason     = s.reason;
		res.fault_code        = s.fault;
		res.ok                = ok;
		res.charger_on        = s.en[EN_CHG];
		res.boost_on          = s.en[EN_BOOST];
		res.buck_on           = s.en[EN_BUCK];
		res.backup_armed      = s.armed;
		res.shutdown_pending  = s.pending;
		res.loss_count        = s.loss_cnt;
		res.backup_ms         = bms;
		res.loss_remaining_ms = rem;
	end

endmodule

FILE: rtl/sbsu_checker.sv
// ----------------------------------------------------------------------------
// sbsu_checker: port-level checks
// Watches the top level's output channel and flags broken record invariants.
// ----------------------------------------------------------------------------
module sbsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);
	import sbsu_pkg::*;

	// A record waiting on the receiver must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output record changed while stalled");

	// The buck converter is never commanded on.
	a_buck: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[13])
		else $error("buck enable reported on");

	// A fault mode always reports a failed step and a latched cause.
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == M_FAULT) |-> !m_tdata[10] && (m_tdata[9:5] != F_NONE))
		else $error("fault mode without failed step or cause");

	// A cutoff reason other than none only appears together with cutoff mode
	// or after start has cleared it, so a cutoff mode must carry a reason.
	a_cut: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == M_CUTOFF) |-> (m_tdata[4:3] != CUT_NONE))
		else $error("cutoff mode without reason");

endmodule

bind supercap_backup_supervisor_unit sbsu_checker u_sbsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/sbsu_scoreboard.sv
// ----------------------------------------------------------------------------
// sbsu_scoreboard: result checker for the backup supervisor
// Watches the command, status and register write channels, runs its own
// model of the supervisor on every input transfer and compares each output
// transfer field by field with the oldest predicted status record.
// ----------------------------------------------------------------------------
module sbsu_scoreboard
	import sbsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output int          fail_count,
	output int          in_flight
);

	cfg_t  lim;
	st_t   sup;
	item_t cur;
	res_t  status_q[$];

	function automatic bit src_good();
		return cur.pg_flags[0] && (cur.pg_flags[1] || cur.pg_flags[2]);
	endfunction

	function automatic bit grace_over(logic [31:0] t);
		logic [31:0] d;
		d = t - sup.loss_start;
		return sup.loss_active && d >= {12'd0, lim.grace_ms};
	endfunction

	function automatic bit ts_bad();
		return cur.ts_mv < TS_MIN_MV || cur.ts_mv > TS_MAX_MV;
	endfunction

	// First half of the split shutdown: the charger goes off at once.
	function automatic bit open_shutdown(logic [31:0] t);
		sup.pending = 1'b1;
		sup.en[EN_CHG] = 1'b0;
		sup.ce_off_done = cur.actions_ok;
		if (cur.actions_ok)
			sup.ce_off_time = t;
		sup.cleanup_good = cur.actions_ok;
		return sup.cleanup_good;
	endfunction

	function automatic bit close_shutdown(logic [31:0] t);
		logic [31:0] d;
		if (!sup.pending)
			return sup.cleanup_good;
		if (!sup.ce_off_done) begin
			sup.en[EN_CHG] = 1'b0;
			sup.ce_off_done = cur.actions_ok;
			if (cur.actions_ok)
				sup.ce_off_time = t;
			sup.cleanup_good = 1'b0;
			return 1'b0;
		end
		d = t - sup.ce_off_time;
		if (d < DECAY_MS)
			return sup.cleanup_good;
		sup.en[EN_BUCK] = 1'b0;
		sup.en[EN_BOOST] = 1'b0;
		sup.cleanup_good = cur.actions_ok;
		if (cur.actions_ok)
			sup.pending = 1'b0;
		return cur.actions_ok;
	endfunction

	function automatic bit trip_fault(fault_t code, logic [31:0] t);
		if (sup.fault == F_NONE)
			sup.fault = code;
		sup.mode = M_FAULT;
		sup.plat_on = 1'b0;
		sup.monitoring = 1'b1;
		if (!sup.pending)
			void'(open_shutdown(t));
		return 1'b0;
	endfunction

	function automatic bit enter_cutoff(reason_t why, logic [31:0] t);
		if (sup.bk_seen && !sup.bk_done) begin
			sup.bk_done_at = t;
			sup.bk_done = 1'b1;
		end
		sup.reason = why;
		sup.mode = M_CUTOFF;
		sup.monitoring = 1'b0;
		return 1'b1;
	endfunction

	function automatic bit sample_tick(logic [31:0] t);
		logic [31:0] d;
		bit mv;
		bit sel, pg5, bpg, stat;
		sel = cur.pg_flags[0];
		pg5 = cur.pg_flags[3];
		bpg = cur.pg_flags[4];
		stat = cur.pg_flags[7];
		if (!sup.monitoring)
			return sup.mode != M_FAULT;
		d = t - sup.last_sample;
		if (d < SAMPLE_MS && !grace_over(t))
			return sup.mode != M_FAULT;
		sup.last_sample = t;
		if (!cur.status_ok) begin
			if (grace_over(t))
				return enter_cutoff(CUT_TIMEOUT, t);
			void'(trip_fault(F_BUS, t));
			void'(close_shutdown(t));
			if (grace_over(t))
				return enter_cutoff(CUT_TIMEOUT, t);
			return 1'b0;
		end
		mv = src_good();
		if (!mv && !sup.loss_active) begin
			sup.loss_active = 1'b1;
			if (sup.loss_cnt != 16'hFFFF)
				sup.loss_cnt++;
			sup.loss_start = t;
			sup.bk_seen = 1'b0;
			sup.bk_done = 1'b0;
			sup.bk_seen_at = '0;
			sup.bk_done_at = '0;
			sup.plat_on = 1'b0;
			if (sup.mode != M_FAULT && !sup.stop_req)
				sup.mode = M_BACKUP;
			if (!open_shutdown(t))
				void'(trip_fault(F_LOSS_SHUT, t));
			if (!sup.armed)
				void'(trip_fault(F_UNARMED, t));
		end
		if (sup.loss_active && !sel && bpg && pg5 && sup.armed && !sup.bk_seen) begin
			sup.bk_seen = 1'b1;
			sup.bk_seen_at = t;
		end
		if (sup.loss_active && mv) begin
			sup.loss_active = 1'b0;
			if (sup.bk_seen && !sup.bk_done) begin
				sup.bk_done_at = t;
				sup.bk_done = 1'b1;
			end
			if (sup.mode != M_FAULT && !sup.stop_req)
				sup.mode = M_RETURNED;
		end
		if (grace_over(t))
			return enter_cutoff(CUT_TIMEOUT, t);
		void'(close_shutdown(t));
		if (!cur.vcap_valid)
			return trip_fault(F_VINVALID, t);
		if (cur.vcap_mv >= lim.trip_mv && sup.mode != M_FAULT)
			return trip_fault(F_OVERVOLT, t);
		if (!mv && sup.armed && cur.vcap_mv <= lim.cutoff_mv)
			return enter_cutoff(CUT_LOWV, t);
		if (!pg5 && sup.mode != M_FAULT)
			return trip_fault(F_PG5V, t);
		if (sup.armed && !bpg && sup.mode != M_FAULT)
			return trip_fault(F_BACKUP_PG, t);

		if (sup.mode == M_CHARGING || sup.mode == M_READY) begin
			if (!cur.pg_flags[5] || !cur.pg_flags[6] || !cur.outputs_ok)
				return trip_fault(F_CHG_STATE, t);
			if (ts_bad())
				return trip_fault(F_THERM, t);
			if (!stat) begin
				if (!sup.stat_low_on) begin
					sup.stat_low_on = 1'b1;
					sup.stat_low_start = t;
				end
				d = t - sup.stat_low_start;
				if (d >= STAT_LOW_MS)
					return trip_fault(F_STAT, t);
			end else begin
				sup.stat_low_on = 1'b0;
			end
			if (!sup.armed && cur.vcap_mv >= lim.arm_mv) begin
				sup.armed = cur.backup_pin;
				if (!cur.actions_ok)
					return trip_fault(F_DRIVER, t);
			end
			if (sup.mode == M_READY && cur.vcap_mv < lim.full_min_mv) begin
				sup.mode = M_CHARGING;
				sup.plat_on = 1'b0;
			end
			if (sup.mode == M_CHARGING) begin
				if (cur.vcap_mv >= lim.full_min_mv && cur.vcap_mv <= lim.full_max_mv
						&& stat) begin
					if (!sup.plat_on) begin
						sup.plat_on = 1'b1;
						sup.plat_start = t;
						sup.plat_low = cur.vcap_mv;
						sup.plat_high = cur.vcap_mv;
					end
					if (cur.vcap_mv < sup.plat_low)
						sup.plat_low = cur.vcap_mv;
					if (cur.vcap_mv > sup.plat_high)
						sup.plat_high = cur.vcap_mv;
					if ({1'b0, sup.plat_high} - {1'b0, sup.plat_low} > {5'd0, lim.span_mv}) begin
						sup.plat_start = t;
						sup.plat_low = cur.vcap_mv;
						sup.plat_high = cur.vcap_mv;
					end
					d = t - sup.plat_start;
					if (d >= {12'd0, lim.plateau_ms} && sup.armed && bpg)
						sup.mode = M_READY;
				end else begin
					sup.plat_on = 1'b0;
				end
				d = t - sup.charge_start;
				if (sup.mode == M_CHARGING && d >= CHARGE_TIMEOUT_MS)
					return trip_fault(F_TIMEOUT, t);
			end
		end
		if (sup.stop_req && !sup.armed && !sup.pending && mv)
			sup.monitoring = 1'b0;
		return sup.mode != M_FAULT;
	endfunction

	function automatic bit start_cmd(logic [31:0] t);
		if (sup.mode == M_CUTOFF)
			return 1'b0;
		if (sup.mode == M_CHARGING || sup.mode == M_READY)
			return 1'b1;
		if (sup.pending)
			return 1'b0;
		sup.fault = F_NONE;
		sup.stop_req = 1'b0;
		sup.cleanup_good = 1'b1;
		if (!cur.budget_ok)
			return trip_fault(F_BUDGET, t);
		if (!cur.status_ok)
			return trip_fault(F_BUS, t);
		if (!src_good() || cur.pg_flags[1] == cur.pg_flags[2] || !cur.pg_flags[3])
			return trip_fault(F_SOURCE, t);
		if (!cur.vcap_valid || cur.vcap_mv >= lim.trip_mv)
			return trip_fault(F_VSTART, t);
		sup.en = '0;
		if (!cur.actions_ok)
			return trip_fault(F_DRIVER, t);
		sup.en[EN_BOOST] = 1'b1;
		if (ts_bad())
			return trip_fault(F_THERM, t);
		sup.en[EN_CHG] = 1'b1;
		sup.mode = M_CHARGING;
		sup.monitoring = 1'b1;
		sup.charge_start = t;
		sup.last_sample = t - SAMPLE_MS;
		sup.loss_start = '0;
		sup.bk_seen_at = '0;
		sup.bk_done_at = '0;
		sup.loss_cnt = '0;
		sup.loss_active = 1'b0;
		sup.bk_seen = 1'b0;
		sup.bk_done = 1'b0;
		sup.reason = CUT_NONE;
		sup.plat_on = 1'b0;
		sup.stat_low_on = 1'b0;
		return sample_tick(t);
	endfunction

	function automatic bit stop_cmd(logic [31:0] t);
		bit good;
		if (sup.mode == M_CUTOFF)
			return 1'b0;
		sup.stop_req = 1'b1;
		sup.mode = M_STOPPED;
		sup.plat_on = 1'b0;
		sup.monitoring = 1'b1;
		good = open_shutdown(t);
		if (cur.status_ok) begin
			if (src_good() && sup.armed) begin
				if (cur.actions_ok)
					sup.armed = 1'b0;
				good = cur.actions_ok && good;
			end
		end else begin
			good = 1'b0;
		end
		if (!good)
			return trip_fault(F_STOP, t);
		return 1'b1;
	endfunction

	function automatic res_t predict_status(item_t it);
		res_t r;
		bit good;
		logic [31:0] t, el;
		cur = it;
		t = it.now_ms;
		case (it.func)
			FN_TICK:  good = sample_tick(t);
			FN_START: good = start_cmd(t);
			FN_STOP:  good = stop_cmd(t);
			default:  good = sup.mode != M_FAULT;
		endcase
		r = '0;
		r.mode = sup.mode;
		r.cutoff_reason = sup.reason;
		r.fault_code = sup.fault;
		r.ok = good;
		r.charger_on = sup.en[EN_CHG];
		r.boost_on = sup.en[EN_BOOST];
		r.buck_on = sup.en[EN_BUCK];
		r.backup_armed = sup.armed;
		r.shutdown_pending = sup.pending;
		r.loss_count = sup.loss_cnt;
		if (sup.bk_seen)
			r.backup_ms = (sup.bk_done ? sup.bk_done_at : t) - sup.bk_seen_at;
		if (sup.loss_active) begin
			el = t - sup.loss_start;
			r.loss_remaining_ms = (el >= {12'd0, lim.grace_ms}) ? 20'd0 :
				lim.grace_ms - el[19:0];
		end
		return r;
	endfunction

	function automatic void check_field(string nm, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch %s: expected %0d, got %0d at %0t", nm, want, got, $realtime);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want, got;
		item_t it;
		if (!arst_n) begin
			lim = CFG_RESET;
			sup = ST_RESET;
			status_q.delete();
			fail_count = 0;
			in_flight = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[83:0];
				if (status_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected status transfer at %0t", $realtime);
				end else begin
					want = status_q.pop_front();
					check_field("mode", want.mode, got.mode);
					check_field("cutoff_reason", want.cutoff_reason, got.cutoff_reason);
					check_field("fault_code", want.fault_code, got.fault_code);
					check_field("ok", want.ok, got.ok);
					check_field("charger_on", want.charger_on, got.charger_on);
					check_field("boost_on", want.boost_on, got.boost_on);
					check_field("buck_on", want.buck_on, got.buck_on);
					check_field("backup_armed", want.backup_armed, got.backup_armed);
					check_field("shutdown_pending", want.shutdown_pending,
						got.shutdown_pending);
					check_field("loss_count", want.loss_count, got.loss_count);
					check_field("backup_ms", want.backup_ms, got.backup_ms);
					check_field("loss_remaining_ms", want.loss_remaining_ms,
						got.loss_remaining_ms);
				end
			end
			if (s_tvalid && s_tready) begin
				it.func = s_tuser;
				it.now_ms = s_tdata[31:0];
				it.budget_ok = s_tdata[32];
				it.status_ok = s_tdata[33];
				it.pg_flags = s_tdata[41:34];
				it.outputs_ok = s_tdata[42];
				it.vcap_valid = s_tdata[43];
				it.vcap_mv = s_tdata[58:44];
				it.ts_mv = s_tdata[70:59];
				it.actions_ok = s_tdata[71];
				it.backup_pin = s_tdata[72];
				status_q.push_back(predict_status(it));
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GRACE:    lim.grace_ms = cfg_data;
					CFG_ARM:      lim.arm_mv = cfg_data[14:0];
					CFG_CUTOFF:   lim.cutoff_mv = cfg_data[14:0];
					CFG_TRIP:     lim.trip_mv = cfg_data[14:0];
					CFG_FULL_MIN: lim.full_min_mv = cfg_data[14:0];
					CFG_FULL_MAX: lim.full_max_mv = cfg_data[14:0];
					CFG_SPAN:     lim.span_mv = cfg_data[10:0];
					CFG_PLATEAU:  lim.plateau_ms = cfg_data;
					default: ;
				endcase
			end
			in_flight = status_q.size();
		end
	end

endmodule

FILE: test/tb_supercap_backup_supervisor_unit.sv
// ----------------------------------------------------------------------------
// tb_supercap_backup_supervisor_unit: regression for the backup supervisor
// Drives directed start, stop and sample sequences, then several register
// settings with randomized charge, plateau and source-loss scenarios; random
// stalls on both channels bar the last two; scoreboard checks each status record.
// ----------------------------------------------------------------------------
module tb_supercap_backup_supervisor_unit;
	import sbsu_pkg::*;

	localparam logic [1:0] FN_SPARE = 2'd3;
	localparam logic [7:0] PG_HEALTHY = 8'b1111_1011;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;
	int          fail_count;
	int          in_flight;

	cfg_t        cur_cfg;
	logic [31:0] clock_ms;
	int          vcap_ramp;
	int          loss_left;
	bit          quiet;
	bit          allow_cut;

	supercap_backup_supervisor_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sbsu_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .in_flight(in_flight)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver side: random bursts of stall and accept; always ready when quiet.
	always @(negedge clk or negedge arst_n) begin
		int left;
		if (!arst_n) begin
			m_tready <= 1'b1;
			left = 0;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (left > 0) begin
			left--;
		end else if ($urandom_range(0, 9) < 3) begin
			m_tready <= 1'b0;
			left = $urandom_range(1, 19);
		end else begin
			m_tready <= 1'b1;
			left = $urandom_range(1, 30);
		end
	end

	function automatic item_t healthy_item(logic [1:0] fn);
		item_t it;
		it.func = fn;
		it.now_ms = clock_ms;
		it.budget_ok = 1'b1;
		it.status_ok = 1'b1;
		it.pg_flags = PG_HEALTHY;
		it.outputs_ok = 1'b1;
		it.vcap_valid = 1'b1;
		it.vcap_mv = 15'd12000;
		it.ts_mv = 12'd1800;
		it.actions_ok = 1'b1;
		it.backup_pin = 1'b1;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(item_t it);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = it.func;
		s_tdata = {7'd0, it.backup_pin, it.actions_ok, it.ts_mv, it.vcap_mv, it.vcap_valid,
			it.outputs_ok, it.pg_flags, it.status_ok, it.budget_ok, it.now_ms};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic tick_after(int gap_ms);
		clock_ms += gap_ms;
		send_item(healthy_item(FN_TICK));
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [19:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (in_flight != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_setting(cfg_t c);
		drain();
		write_reg(CFG_GRACE, c.grace_ms);
		write_reg(CFG_ARM, {5'd0, c.arm_mv});
		write_reg(CFG_CUTOFF, {5'd0, c.cutoff_mv});
		write_reg(CFG_TRIP, {5'd0, c.trip_mv});
		write_reg(CFG_FULL_MIN, {5'd0, c.full_min_mv});
		write_reg(CFG_FULL_MAX, {5'd0, c.full_max_mv});
		write_reg(CFG_SPAN, {9'd0, c.span_mv});
		write_reg(CFG_PLATEAU, c.plateau_ms);
		cur_cfg = c;
	endtask

	function automatic logic [14:0] pick_vcap();
		int p;
		int lo, hi;
		p = $urandom_range(0, 99);
		lo = cur_cfg.full_min_mv;
		hi = cur_cfg.full_max_mv;
		if (p < 55) begin
			vcap_ramp += $urandom_range(0, 400);
			if (vcap_ramp > hi && vcap_ramp > lo)
				vcap_ramp = $urandom_range(lo, hi);
			return vcap_ramp[14:0];
		end else if (p < 80) begin
			return 15'($urandom_range(lo, hi));
		end else if (p < 94) begin
			case ($urandom_range(0, 4))
				0: return 15'(cur_cfg.arm_mv + $urandom_range(0, 2) - 1);
				1: return 15'(cur_cfg.cutoff_mv + $urandom_range(0, 2) - 1);
				2: return 15'(cur_cfg.trip_mv + $urandom_range(0, 2) - 1);
				3: return 15'(lo + $urandom_range(0, 2) - 1);
				default: return 15'(hi + $urandom_range(0, 2) - 1);
			endcase
		end
		return 15'($urandom_range(0, 32767));
	endfunction

	function automatic item_t random_item();
		item_t it;
		int p;
		p = $urandom_range(0, 99);
		it = healthy_item(FN_TICK);
		if (p < 4)
			it.func = FN_START;
		else if (p < 7)
			it.func = FN_STOP;
		else if (p < 8)
			it.func = FN_SPARE;
		p = $urandom_range(0, 99);
		if (p < 3 && loss_left == 0)
			clock_ms = $urandom;
		else if (p < 12)
			clock_ms += $urandom_range(0, 19);
		else
			clock_ms += $urandom_range(20, 60);
		it.now_ms = clock_ms;
		if (it.func == FN_START)
			vcap_ramp = $urandom_range(0, cur_cfg.arm_mv + 500);
		if (loss_left == 0 && $urandom_range(0, 99) < 4)
			loss_left = allow_cut ? $urandom_range(1, 40) : $urandom_range(1, 6);
		if (loss_left > 0) begin
			loss_left--;
			it.pg_flags = {4'($urandom_range(0, 15)), 4'b1000};
			it.pg_flags[4] = $urandom_range(0, 9) != 0;
		end else begin
			it.pg_flags = PG_HEALTHY;
			if ($urandom_range(0, 1))
				it.pg_flags[2:1] = 2'b10;
			it.pg_flags[7] = $urandom_range(0, 99) >= 8;
		end
		if ($urandom_range(0, 99) < 6)
			it.pg_flags[3'($urandom_range(0, 7))] ^= 1'b1;
		it.vcap_mv = pick_vcap();
		if (loss_left > 0 && !allow_cut && it.vcap_mv <= cur_cfg.cutoff_mv)
			it.vcap_mv = 15'(cur_cfg.cutoff_mv + 1 + $urandom_range(0, 500));
		it.ts_mv = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) :
			12'($urandom_range(TS_MIN_MV, TS_MAX_MV));
		it.budget_ok = $urandom_range(0, 99) < 85;
		it.status_ok = $urandom_range(0, 99) < 97;
		it.outputs_ok = $urandom_range(0, 99) < 98;
		it.vcap_valid = $urandom_range(0, 99) < 98;
		it.actions_ok = $urandom_range(0, 99) < 96;
		it.backup_pin = $urandom_range(0, 99) < 90;
		return it;
	endfunction

	task automatic random_phase(cfg_t c, int count);
		load_setting(c);
		repeat (count)
			send_item(random_item());
	endtask

	initial begin
		item_t it;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FN_TICK;
		cfg_we = 1'b0;
		cfg_index = CFG_GRACE;
		cfg_data = '0;
		quiet = 1'b0;
		allow_cut = 1'b0;
		loss_left = 0;
		vcap_ramp = 9000;
		cur_cfg = CFG_RESET;
		clock_ms = 32'hFFFF_F000;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Idle block: ticks are ignored, the spare code too, stop starts a shutdown.
		send_item(healthy_item(FN_TICK));
		send_item(healthy_item(FN_SPARE));
		send_item(healthy_item(FN_STOP));
		tick_after(120);
		tick_after(120);
		// Each start refusal, with the shutdown flushed after it.
		for (int k = 0; k < 6; k++) begin
			it = healthy_item(FN_START);
			case (k)
				0: it.budget_ok = 1'b0;
				1: it.status_ok = 1'b0;
				2: it.pg_flags[2:1] = 2'b11;
				3: it.vcap_mv = 15'h7FFF;
				4: it.actions_ok = 1'b0;
				default: it.ts_mv = 12'hFFF;
			endcase
			send_item(it);
			tick_after(120);
			tick_after(120);
		end
		// A good start, a too-early sample, then a regular sample and a source loss.
		send_item(healthy_item(FN_START));
		tick_after(5);
		tick_after(20);
		it = healthy_item(FN_TICK);
		clock_ms += 20;
		it.now_ms = clock_ms;
		it.pg_flags = 8'b0011_1000;
		send_item(it);

		random_phase('{grace_ms: 600000, arm_mv: 10000, cutoff_mv: 7000, trip_mv: 21000,
			full_min_mv: 20000, full_max_mv: 20950, span_mv: 150, plateau_ms: 300}, 100);
		random_phase('{grace_ms: 400000, arm_mv: 0, cutoff_mv: 0, trip_mv: 25000,
			full_min_mv: 0, full_max_mv: 25000, span_mv: 0, plateau_ms: 0}, 100);
		random_phase('{grace_ms: 600000, arm_mv: 5000, cutoff_mv: 3000, trip_mv: 15000,
			full_min_mv: 14000, full_max_mv: 14500, span_mv: 2000, plateau_ms: 600000}, 100);
		random_phase('{grace_ms: 1000, arm_mv: 12000, cutoff_mv: 9000, trip_mv: 24000,
			full_min_mv: 23000, full_max_mv: 23500, span_mv: 1, plateau_ms: 100}, 100);
		quiet = 1'b1;
		allow_cut = 1'b1;
		random_phase('{grace_ms: 300, arm_mv: 8000, cutoff_mv: 6000, trip_mv: 25000,
			full_min_mv: 20000, full_max_mv: 20950, span_mv: 150, plateau_ms: 100}, 100);
		random_phase('{grace_ms: 0, arm_mv: 25000, cutoff_mv: 25000, trip_mv: 0,
			full_min_mv: 25000, full_max_mv: 0, span_mv: 2000, plateau_ms: 0}, 40);

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
